@@ rtl/bmcs_pkg.sv @@
// ----------------------------------------------------------------------------
// bmcs_pkg: button map CRC summariser package
// Beat types, limits and the CRC16-CCITT byte update.
// ----------------------------------------------------------------------------
package bmcs_pkg;

  localparam int MaxButtons = 128;

  localparam logic [15:0] CrcInit = 16'hFFFF;
  localparam logic [15:0] CrcPoly = 16'h1021;
  localparam logic [15:0] CrcZero = 16'h0000;

  localparam logic [1:0] KindPin       = 2'd0;
  localparam logic [1:0] KindMatrix    = 2'd1;
  localparam logic [1:0] KindShiftReg  = 2'd2;
  localparam logic [1:0] KindNonButton = 2'd3;

  typedef struct packed {
    logic [1:0] input_kind;
    logic [7:0] button_id;
    logic       last_input;
  } in_beat_t;

  typedef struct packed {
    logic [7:0]  btn_total;
    logic [3:0]  axes_on;
    logic [15:0] id_crc;
  } out_beat_t;

  // MSB first, no reflection, no final XOR
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CrcPoly;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

  function automatic logic [3:0] popcount8(input logic [7:0] v);
    logic [3:0] n;
    n = 4'd0;
    for (int k = 0; k < 8; k++) begin
      n = n + {3'd0, v[k]};
    end
    return n;
  endfunction

endpackage

@@ rtl/button_map_crc_summarizer.sv @@
// ----------------------------------------------------------------------------
// button_map_crc_summarizer: button map CRC summariser
// Folds button ids into a CRC16-CCITT and emits one summary per list.
// ----------------------------------------------------------------------------
// Usage
//   Input channel (in_valid/in_ready/in_data): one beat per logical input.
//   Kinds pin, matrix and shift register are buttons; non-button beats only
//   matter when they carry last_input. Buttons past the 128th are ignored.
//   Output channel (out_valid/out_ready/out_data): one summary beat per
//   list, issued for the beat marked last_input: button count, number of
//   enabled axes and the CRC (zero when every id equals its position).
//   cfg_we/cfg_wdata write the axis enable mask; write it only while idle.
// Timing and throughput
//   The summary appears in the cycle after the last beat is taken. One beat
//   per cycle is accepted; the only storage between the channels is the
//   output register, so in_ready is high whenever that register is empty
//   or being drained in the same cycle.
// Reset
//   rst (synchronous) clears the list state (CRC 0xFFFF, sequential, count
//   0), the axis mask and the output valid.
// Stall
//   While out_valid is held by a low out_ready, in_ready drops and the
//   list state is frozen; no beat is lost.
// ----------------------------------------------------------------------------
module button_map_crc_summarizer (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  bmcs_pkg::in_beat_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output bmcs_pkg::out_beat_t out_data,
  input  logic                cfg_we,
  input  logic [7:0]          cfg_wdata
);

  // list state
  logic [15:0] running_crc;
  logic        is_sequential;
  logic [7:0]  mapped_count;
  logic [7:0]  axis_enable_mask;

  logic [15:0] running_crc_next;
  logic        is_sequential_next;
  logic [7:0]  mapped_count_next;

  logic        accept;
  logic        take_button;
  logic        is_button;

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  assign is_button   = (in_data.input_kind != bmcs_pkg::KindNonButton);
  // saturate: once the map is full further buttons are dropped entirely
  assign take_button = is_button && (mapped_count < 8'(bmcs_pkg::MaxButtons));

  always_comb begin
    running_crc_next   = running_crc;
    is_sequential_next = is_sequential;
    mapped_count_next  = mapped_count;
    if (take_button) begin
      running_crc_next  = bmcs_pkg::crc_byte(running_crc, in_data.button_id);
      mapped_count_next = mapped_count + 8'd1;
      if (in_data.button_id != mapped_count) begin
        is_sequential_next = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_crc   <= bmcs_pkg::CrcInit;
      is_sequential <= 1'b1;
      mapped_count  <= 8'd0;
    end else if (accept) begin
      if (in_data.last_input) begin
        // end of list: back to the empty-list state
        running_crc   <= bmcs_pkg::CrcInit;
        is_sequential <= 1'b1;
        mapped_count  <= 8'd0;
      end else begin
        running_crc   <= running_crc_next;
        is_sequential <= is_sequential_next;
        mapped_count  <= mapped_count_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      axis_enable_mask <= 8'd0;
    end else if (cfg_we) begin
      axis_enable_mask <= cfg_wdata;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= in_data.last_input;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && in_data.last_input) begin
      out_data.btn_total <= mapped_count_next;
      out_data.axes_on   <= bmcs_pkg::popcount8(axis_enable_mask);
      out_data.id_crc    <= is_sequential_next ? bmcs_pkg::CrcZero : running_crc_next;
    end
  end

endmodule

@@ rtl/bmcs_checker.sv @@
// ----------------------------------------------------------------------------
// bmcs_checker: port-level checks for the button map CRC summariser
// Watches the top-level ports; attached by bind.
// ----------------------------------------------------------------------------
module bmcs_checker (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_ready,
  input bmcs_pkg::in_beat_t  in_data,
  input logic                out_valid,
  input logic                out_ready,
  input bmcs_pkg::out_beat_t out_data
);

  // a stalled summary beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("summary beat changed while stalled");

  // exactly the last beat of a list produces a summary, in the following cycle
  a_last_gives_summary: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> out_valid == $past(in_data.last_input))
    else $error("summary not matched to last beat");

  // no skid: input taken only when the output register can be freed
  a_ready_rule: assert property (@(posedge clk) disable iff (rst)
    in_ready == (!out_valid || out_ready))
    else $error("in_ready inconsistent with output register");

  // saturating count and bounded axis count
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.btn_total <= 8'd128) && (out_data.axes_on <= 4'd8))
    else $error("summary count out of range");

  // an empty map is sequential, so its CRC reads as zero
  a_empty_crc: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.btn_total == 8'd0) |-> out_data.id_crc == 16'h0000)
    else $error("empty map with non-zero CRC");

endmodule

bind button_map_crc_summarizer bmcs_checker u_bmcs_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

@@ tb/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top: button map CRC summariser testbench
// Beat lists go in through a queued driver with random gaps, and summaries
// are taken by a monitor with random stalls. Each summary is checked field
// by field against a behavioural CRC16-CCITT list tracker. The axis mask is
// rewritten between phases while the block is idle.
// ----------------------------------------------------------------------------
module tb_top;

  typedef struct {
    bmcs_pkg::in_beat_t beat;
    int       gap;    // idle cycles before the beat is offered
    bit       drain;  // hold the beat back until every summary is in
  } stim_t;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_ready;
  bmcs_pkg::in_beat_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  bmcs_pkg::out_beat_t out_data;
  logic      cfg_we = 1'b0;
  logic [7:0] cfg_wdata = 8'h00;

  button_map_crc_summarizer DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // beats waiting to be driven, summaries still owed by the block
  stim_t     beat_q[$];
  bmcs_pkg::out_beat_t summary_q[$];

  // list tracker state and its copy of the mask
  logic [15:0] list_crc = bmcs_pkg::CrcInit;
  logic        list_seq = 1'b1;
  logic [7:0]  list_count = 8'd0;
  logic [7:0]  axis_mask = 8'h00;

  // idling knobs: 0 none, 1 random idling on every beat, 2 mostly none with bursts
  int in_gap_mode = 1;
  int out_stall_mode = 1;

  int err_cnt = 0;
  int stim_cnt = 0;
  int gap_cnt = 0;
  int ready_wait = 0;
  stim_t nxt;

  initial begin
    forever #5 clk = ~clk;
  end

  // a generous ceiling: far beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("tb_top: done, errors");
    $finish;
  end

  task automatic report(input string msg);
    $display("MISMATCH @%0t: %s", $time, msg);
    err_cnt++;
  endtask

  // Tracks the list state for one accepted beat; a last beat yields the
  // summary the block owes and clears the list (the mask stays).
  task automatic fold_beat(input bmcs_pkg::in_beat_t b);
    bmcs_pkg::out_beat_t s;
    logic fb;
    // buttons past the limit leave CRC, count and sequence flag alone
    if (b.input_kind != bmcs_pkg::KindNonButton &&
        list_count < 8'(bmcs_pkg::MaxButtons)) begin
      if (b.button_id != list_count) list_seq = 1'b0;
      // bit-serial CCITT, MSB first
      for (int i = 7; i >= 0; i--) begin
        fb = list_crc[15] ^ b.button_id[i];
        list_crc = {list_crc[14:0], 1'b0} ^ (fb ? bmcs_pkg::CrcPoly : bmcs_pkg::CrcZero);
      end
      list_count = list_count + 8'd1;
    end
    if (b.last_input) begin
      s.btn_total = list_count;
      s.axes_on = 4'd0;
      for (int i = 0; i < 8; i++) s.axes_on = s.axes_on + {3'd0, axis_mask[i]};
      s.id_crc = list_seq ? bmcs_pkg::CrcZero : list_crc;
      summary_q.push_back(s);
      list_crc = bmcs_pkg::CrcInit;
      list_seq = 1'b1;
      list_count = 8'd0;
    end
  endtask

  task automatic push_beat(input logic [1:0] kind, input logic [7:0] id, input bit last);
    stim_t s;
    s.beat.input_kind = kind;
    s.beat.button_id = id;
    s.beat.last_input = last;
    case (in_gap_mode)
      0: s.gap = 0;
      1: s.gap = $urandom_range(0, 16);
      default: s.gap = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 16) : 0;
    endcase
    s.drain = ($urandom_range(0, 199) == 0);
    beat_q.push_back(s);
    stim_cnt++;
  endtask

  // Long list to hit the 128-button ceiling; extra buttons past it are ignored.
  task automatic add_long_list(input bit seq, input int nbtn, input int extra);
    int pos;
    pos = 0;
    while (pos < nbtn + extra) begin
      if ($urandom_range(0, 9) == 0) begin
        push_beat(bmcs_pkg::KindNonButton, 8'($urandom_range(0, 255)), 1'b0);
      end else begin
        push_beat(2'($urandom_range(0, 2)),
                  (seq && pos < nbtn) ? 8'(pos) : 8'($urandom_range(0, 255)),
                  pos == nbtn + extra - 1);
        pos++;
      end
    end
  endtask

  // Settled: nothing queued, nothing on the wire and no summary owed; then it
  // idles on so that the output register can clear.
  task automatic wait_idle();
    do @(negedge clk); while (beat_q.size() != 0 || in_valid || summary_q.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Driver: offers the front of beat_q after its gap. A beat marked drain is
  // held until the block has delivered every summary owed so far.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      gap_cnt = 0;
    end else begin
      if (in_valid && in_ready) fold_beat(in_data);
      if (!in_valid || in_ready) begin
        if (beat_q.size() == 0 || (beat_q[0].drain && summary_q.size() != 0)) begin
          in_valid <= 1'b0;
        end else if (gap_cnt < beat_q[0].gap) begin
          gap_cnt++;
          in_valid <= 1'b0;
        end else begin
          nxt = beat_q.pop_front();
          in_data <= nxt.beat;
          in_valid <= 1'b1;
          gap_cnt = 0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: checks each summary beat against the oldest one owed, then draws
  // a fresh stall before taking the next.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    bmcs_pkg::out_beat_t want;
    if (rst) begin
      out_ready <= 1'b0;
      ready_wait = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (summary_q.size() == 0) begin
          report($sformatf("summary beat with none owed: %0d/%0d/%04h",
                           out_data.btn_total, out_data.axes_on,
                           out_data.id_crc));
        end else begin
          want = summary_q.pop_front();
          if (out_data.btn_total !== want.btn_total)
            report($sformatf("btn_total %0d, want %0d",
                             out_data.btn_total, want.btn_total));
          if (out_data.axes_on !== want.axes_on)
            report($sformatf("axes_on %0d, want %0d",
                             out_data.axes_on, want.axes_on));
          if (out_data.id_crc !== want.id_crc)
            report($sformatf("id_crc %04h, want %04h",
                             out_data.id_crc, want.id_crc));
        end
        case (out_stall_mode)
          0: ready_wait = 0;
          1: ready_wait = $urandom_range(0, 16);
          default: ready_wait = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 16) : 0;
        endcase
      end else if (ready_wait > 0) begin
        ready_wait--;
      end
      out_ready <= (ready_wait == 0);
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus: directed lists under the reset mask, then eight random phases,
  // each behind a mask write made while idle.
  // ---------------------------------------------------------------------------
  initial begin
    logic [7:0] masks[8];
    int len, pos, bad, shape;
    logic [1:0] kind;
    logic [7:0] id;

    masks = '{8'hFF, 8'h00, 8'h80, 8'h01, 8'h00, 8'h7E, 8'h00, 8'hFF};
    masks[4] = 8'($urandom_range(0, 255));
    masks[6] = 8'($urandom_range(0, 255));

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // empty list closed by a non-button
    push_beat(bmcs_pkg::KindNonButton, 8'hFF, 1'b1);
    // single buttons: in sequence, and not
    push_beat(bmcs_pkg::KindPin, 8'h00, 1'b1);
    push_beat(bmcs_pkg::KindMatrix, 8'hFF, 1'b1);
    // sequential with a skipped non-button, closed by a button
    push_beat(bmcs_pkg::KindShiftReg, 8'h00, 1'b0);
    push_beat(bmcs_pkg::KindNonButton, 8'hAA, 1'b0);
    push_beat(bmcs_pkg::KindMatrix, 8'h01, 1'b0);
    push_beat(bmcs_pkg::KindPin, 8'h02, 1'b1);
    // out of sequence, closed by a non-button
    push_beat(bmcs_pkg::KindPin, 8'h80, 1'b0);
    push_beat(bmcs_pkg::KindShiftReg, 8'h7F, 1'b0);
    push_beat(bmcs_pkg::KindNonButton, 8'h55, 1'b1);
    push_beat(bmcs_pkg::KindPin, 8'h01, 1'b1);
    // non-buttons only
    push_beat(bmcs_pkg::KindNonButton, 8'h00, 1'b0);
    push_beat(bmcs_pkg::KindNonButton, 8'h00, 1'b1);
    // the sender waits for every summary before the list with the skipped non-button goes in
    beat_q[3].drain = 1'b1;

    for (int p = 0; p < 8; p++) begin
      wait_idle();
      @(posedge clk);
      cfg_we <= 1'b1;
      cfg_wdata <= masks[p];
      @(posedge clk);
      cfg_we <= 1'b0;
      axis_mask = masks[p];
      @(negedge clk);

      in_gap_mode = p % 3;
      out_stall_mode = (p + p / 3) % 3;
      stim_cnt = 0;

      if (p == 3) begin
        add_long_list(1'b1, 128, 20);
        add_long_list(1'b0, 140, 0);
      end else if (p == 6) begin
        add_long_list(1'b1, 128, 0);
      end

      while (stim_cnt < 215) begin
        shape = $urandom_range(0, 9);
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
        bad = (shape == 4) ? $urandom_range(0, len - 1) : -1;
        pos = 0;
        for (int i = 0; i < len; i++) begin
          if (shape >= 8) begin
            // noise: anything, last mark at random
            push_beat(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                      1'($urandom_range(0, 1)));
          end else if ($urandom_range(0, 99) < 15) begin
            push_beat(bmcs_pkg::KindNonButton, 8'($urandom_range(0, 255)), i == len - 1);
          end else begin
            kind = 2'($urandom_range(0, 2));
            if (shape <= 4) begin
              id = 8'(pos);
              // sequential ids; in shape 4 at most one is knocked off by a single bit
              if (i == bad) id = id ^ (8'd1 << $urandom_range(0, 7));
            end else begin
              id = 8'($urandom_range(0, 255));
            end
            push_beat(kind, id, i == len - 1);
            pos++;
          end
        end
      end
    end

    wait_idle();
    repeat (8) @(negedge clk);
    if (err_cnt == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/bmcs_pkg.sv
rtl/button_map_crc_summarizer.sv
rtl/bmcs_checker.sv
tb/tb_top.sv
